// ===== rtl/hcq_pkg.sv =====
package hcq_pkg;

  localparam int unsigned DEF_PAGE_BITS = 14;
  localparam int unsigned HOT_DEPTH     = 16;
  localparam int unsigned COLD_DEPTH    = 16;
  localparam int unsigned MAX_DEPTH     = (HOT_DEPTH > COLD_DEPTH) ? HOT_DEPTH : COLD_DEPTH;
  localparam int unsigned LIST_AW       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned POS_W         = 4;
  localparam int unsigned CAP_RESET     = 16;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_READ   = 1'b1;
  localparam logic SEL_HOT   = 1'b0;
  localparam logic SEL_COLD  = 1'b1;

  localparam logic REG_HOT_CAP  = 1'b0;
  localparam logic REG_COLD_CAP = 1'b1;

  typedef enum logic [1:0] {
    HIT_MISS = 2'd0,
    HIT_COLD = 2'd1,
    HIT_HOT  = 2'd2
  } hit_kind_e;

  typedef enum logic [2:0] {
    LOP_HOLD       = 3'd0,
    LOP_REMOVE     = 3'd1,
    LOP_POP_TAIL   = 3'd2,
    LOP_PUSH       = 3'd3,
    LOP_PUSH_EVICT = 3'd4,
    LOP_MOVE_FRONT = 3'd5
  } list_op_e;

  typedef struct packed {
    list_op_e             op;
    logic [LIST_AW-1:0]   idx;
  } list_cmd_t;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] depth);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > depth) begin
      r = depth;
    end
    return r;
  endfunction

endpackage

// ===== rtl/hot_cold_two_queue_replacement.sv =====
// An access walks the cold list and, on a cold miss, the hot list with the single page
// comparator, one entry per cycle.
// Throughput: one transaction at a time; s_axis_tready is high only when idle.
// Reset (rst_ni, async, active low) empties both lists and sets both capacities to 16.
module hot_cold_two_queue_replacement import hcq_pkg::*; #(
  parameter int unsigned PAGE_BITS = DEF_PAGE_BITS,
  localparam int unsigned IN_W  = ((PAGE_BITS + POS_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * PAGE_BITS + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // page, position
  input  logic [1:0]       s_axis_tuser,  // op, list_select
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // read_page, dropped_page, hot_count, cold_count
  output logic [3:0]       m_axis_tuser,  // hit_kind[1:0], read_valid, dropped_valid
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CNT_W-1:0]     hot_cap_q, cold_cap_q;
  logic [CNT_W-1:0]     hot_new_cap, cold_new_cap;
  logic                 cfg_wr, hot_trim, cold_trim;

  list_cmd_t            hot_cmd, cold_cmd;
  logic [PAGE_BITS-1:0] hot_wpage, cold_wpage, hot_rd, cold_rd;
  logic [LIST_AW-1:0]   hot_addr, cold_addr;
  logic [CNT_W-1:0]     hot_fill, cold_fill;

  logic [1:0]           hit_kind;
  logic                 read_valid, drop_valid;
  logic [PAGE_BITS-1:0] read_page, drop_page;
  logic [CNT_W-1:0]     hot_count, cold_count;

  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign hot_new_cap  = clamp_cap(pwdata[CNT_W-1:0], CNT_W'(HOT_DEPTH));
  assign cold_new_cap = clamp_cap(pwdata[CNT_W-1:0], CNT_W'(COLD_DEPTH));
  assign hot_trim     = cfg_wr && (paddr[2] == REG_HOT_CAP);
  assign cold_trim    = cfg_wr && (paddr[2] == REG_COLD_CAP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_cap_q  <= clamp_cap(CNT_W'(CAP_RESET), CNT_W'(HOT_DEPTH));
      cold_cap_q <= clamp_cap(CNT_W'(CAP_RESET), CNT_W'(COLD_DEPTH));
    end else begin
      if (hot_trim)  hot_cap_q  <= hot_new_cap;
      if (cold_trim) cold_cap_q <= cold_new_cap;
    end
  end

  assign prdata = (paddr[2] == REG_COLD_CAP) ? 32'(cold_cap_q) : 32'(hot_cap_q);

  hcq_list #(
    .DEPTH     (HOT_DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_hot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (hot_cmd),
    .page_i     (hot_wpage),
    .trim_i     (hot_trim),
    .trim_cap_i (hot_new_cap),
    .rd_addr_i  (hot_addr),
    .rd_page_o  (hot_rd),
    .fill_o     (hot_fill)
  );

  hcq_list #(
    .DEPTH     (COLD_DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_cold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cold_cmd),
    .page_i     (cold_wpage),
    .trim_i     (cold_trim),
    .trim_cap_i (cold_new_cap),
    .rd_addr_i  (cold_addr),
    .rd_page_o  (cold_rd),
    .fill_o     (cold_fill)
  );

  hcq_ctrl #(
    .PAGE_BITS (PAGE_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_op_i          (s_axis_tuser[0]),
    .in_page_i        (s_axis_tdata[PAGE_BITS-1:0]),
    .in_sel_i         (s_axis_tuser[1]),
    .in_pos_i         (s_axis_tdata[PAGE_BITS +: POS_W]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_hit_kind_o   (hit_kind),
    .out_read_valid_o (read_valid),
    .out_read_page_o  (read_page),
    .out_drop_valid_o (drop_valid),
    .out_drop_page_o  (drop_page),
    .out_hot_count_o  (hot_count),
    .out_cold_count_o (cold_count),
    .hot_cap_i        (hot_cap_q),
    .cold_cap_i       (cold_cap_q),
    .hot_cmd_o        (hot_cmd),
    .hot_page_o       (hot_wpage),
    .hot_addr_o       (hot_addr),
    .hot_rd_i         (hot_rd),
    .hot_fill_i       (hot_fill),
    .cold_cmd_o       (cold_cmd),
    .cold_page_o      (cold_wpage),
    .cold_addr_o      (cold_addr),
    .cold_rd_i        (cold_rd),
    .cold_fill_i      (cold_fill)
  );

  assign m_axis_tdata = OUT_W'({cold_count, hot_count, drop_page, read_page});
  assign m_axis_tuser = {drop_valid, read_valid, hit_kind};

endmodule

// ===== rtl/hcq_list.sv =====
module hcq_list import hcq_pkg::*; #(
  parameter int unsigned DEPTH     = HOT_DEPTH,
  parameter int unsigned PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  list_cmd_t            cmd_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 trim_i,
  input  logic [CNT_W-1:0]     trim_cap_i,
  input  logic [LIST_AW-1:0]   rd_addr_i,
  output logic [PAGE_BITS-1:0] rd_page_o,
  output logic [CNT_W-1:0]     fill_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PAGE_BITS-1:0] mem_q [DEPTH];
  logic [CNT_W-1:0]     fill_q, fill_d;

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    localparam logic [LIST_AW-1:0] K = LIST_AW'(k);
    logic [PAGE_BITS-1:0] up_w;
    logic [PAGE_BITS-1:0] dn_w;

    if (k == 0) begin : g_head
      assign up_w = page_i;
    end else begin : g_body
      assign up_w = mem_q[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign dn_w = mem_q[k];
    end else begin : g_inner
      assign dn_w = mem_q[k+1];
    end

    always_ff @(posedge clk_i) begin
      case (cmd_i.op)
        LOP_REMOVE: begin
          if (K >= cmd_i.idx) mem_q[k] <= dn_w;
        end
        LOP_PUSH, LOP_PUSH_EVICT: begin
          mem_q[k] <= up_w;
        end
        LOP_MOVE_FRONT: begin
          if (K <= cmd_i.idx) mem_q[k] <= up_w;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.op)
      LOP_REMOVE, LOP_POP_TAIL: fill_d = fill_q - CNT_W'(1);
      LOP_PUSH:                 fill_d = fill_q + CNT_W'(1);
      default:                  fill_d = fill_q;
    endcase
    if (trim_i && (fill_q > trim_cap_i)) begin
      fill_d = trim_cap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign rd_page_o = mem_q[rd_addr_i[AW-1:0]];
  assign fill_o    = fill_q;

endmodule

// ===== rtl/hcq_ctrl.sv =====
module hcq_ctrl import hcq_pkg::*; #(
  parameter int unsigned PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_op_i,
  input  logic [PAGE_BITS-1:0] in_page_i,
  input  logic                 in_sel_i,
  input  logic [POS_W-1:0]     in_pos_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_hit_kind_o,
  output logic                 out_read_valid_o,
  output logic [PAGE_BITS-1:0] out_read_page_o,
  output logic                 out_drop_valid_o,
  output logic [PAGE_BITS-1:0] out_drop_page_o,
  output logic [CNT_W-1:0]     out_hot_count_o,
  output logic [CNT_W-1:0]     out_cold_count_o,
  input  logic [CNT_W-1:0]     hot_cap_i,
  input  logic [CNT_W-1:0]     cold_cap_i,
  output list_cmd_t            hot_cmd_o,
  output logic [PAGE_BITS-1:0] hot_page_o,
  output logic [LIST_AW-1:0]   hot_addr_o,
  input  logic [PAGE_BITS-1:0] hot_rd_i,
  input  logic [CNT_W-1:0]     hot_fill_i,
  output list_cmd_t            cold_cmd_o,
  output logic [PAGE_BITS-1:0] cold_page_o,
  output logic [LIST_AW-1:0]   cold_addr_o,
  input  logic [PAGE_BITS-1:0] cold_rd_i,
  input  logic [CNT_W-1:0]     cold_fill_i
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SCAN_COLD = 9'b000000010,
    S_SCAN_HOT  = 9'b000000100,
    S_COLD_HIT  = 9'b000001000,
    S_COLD_MOVE = 9'b000010000,
    S_HOT_MOVE  = 9'b000100000,
    S_MISS      = 9'b001000000,
    S_READ      = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic                 op_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 sel_q;
  logic [POS_W-1:0]     pos_q;
  logic [CNT_W-1:0]     scan_q;
  logic [LIST_AW-1:0]   hit_idx_q;
  logic                 demote_q;
  logic [PAGE_BITS-1:0] tail_q;
  hit_kind_e            hit_kind_q;
  logic                 read_valid_q;
  logic [PAGE_BITS-1:0] read_page_q;
  logic                 drop_valid_q;
  logic [PAGE_BITS-1:0] drop_page_q;
  logic                 out_valid_q, out_valid_d;

  logic [CNT_W-1:0]     hot_tail_w, cold_tail_w;
  logic [PAGE_BITS-1:0] cmp_page_w;
  logic                 match_w;
  logic                 hot_full_w, cold_full_w;
  logic                 accept_w, emit_w;
  logic                 rd_valid_w;

  assign hot_tail_w  = hot_fill_i - CNT_W'(1);
  assign cold_tail_w = cold_fill_i - CNT_W'(1);
  assign hot_full_w  = (hot_fill_i >= hot_cap_i) && (hot_fill_i != '0);
  assign cold_full_w = (cold_fill_i >= cold_cap_i) && (cold_fill_i != '0);

  assign cmp_page_w = (state_q == S_SCAN_HOT) ? hot_rd_i : cold_rd_i;
  assign match_w    = (cmp_page_w == page_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept_w   = in_valid_i && in_ready_o;
  assign emit_w     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign rd_valid_w = (sel_q == SEL_COLD) ? ({1'b0, pos_q} < cold_fill_i)
                                          : ({1'b0, pos_q} < hot_fill_i);

  always_comb begin
    hot_addr_o  = scan_q[LIST_AW-1:0];
    cold_addr_o = scan_q[LIST_AW-1:0];
    case (state_q)
      S_COLD_HIT: hot_addr_o  = hot_tail_w[LIST_AW-1:0];
      S_MISS:     cold_addr_o = cold_tail_w[LIST_AW-1:0];
      S_READ: begin
        hot_addr_o  = LIST_AW'(pos_q);
        cold_addr_o = LIST_AW'(pos_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    hot_cmd_o   = '{op: LOP_HOLD, idx: hit_idx_q};
    cold_cmd_o  = '{op: LOP_HOLD, idx: hit_idx_q};
    hot_page_o  = page_q;
    cold_page_o = page_q;
    case (state_q)
      S_COLD_HIT: begin
        cold_cmd_o.op = LOP_REMOVE;
        if (hot_full_w) hot_cmd_o.op = LOP_POP_TAIL;
      end
      S_COLD_MOVE: begin
        hot_cmd_o.op = LOP_PUSH;
        cold_page_o  = tail_q;
        if (demote_q && (cold_fill_i < cold_cap_i)) cold_cmd_o.op = LOP_PUSH;
      end
      S_HOT_MOVE: begin
        hot_cmd_o.op = LOP_MOVE_FRONT;
      end
      S_MISS: begin
        cold_cmd_o.op = cold_full_w ? LOP_PUSH_EVICT : LOP_PUSH;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept_w) state_d = (in_op_i == OP_READ) ? S_READ : S_SCAN_COLD;
      end
      S_SCAN_COLD: begin
        if (scan_q >= cold_fill_i) begin
          state_d = S_SCAN_HOT;
        end else if (match_w) begin
          state_d = S_COLD_HIT;
        end
      end
      S_SCAN_HOT: begin
        if (scan_q >= hot_fill_i) begin
          state_d = S_MISS;
        end else if (match_w) begin
          state_d = S_HOT_MOVE;
        end
      end
      S_COLD_HIT:  state_d = S_COLD_MOVE;
      S_COLD_MOVE: state_d = S_DONE;
      S_HOT_MOVE:  state_d = S_DONE;
      S_MISS:      state_d = S_DONE;
      S_READ:      state_d = S_DONE;
      S_DONE: begin
        if (emit_w) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q         <= in_op_i;
        page_q       <= in_page_i;
        sel_q        <= in_sel_i;
        pos_q        <= in_pos_i;
        scan_q       <= '0;
        demote_q     <= 1'b0;
        hit_kind_q   <= HIT_MISS;
        read_valid_q <= 1'b0;
        read_page_q  <= '0;
        drop_valid_q <= 1'b0;
        drop_page_q  <= '0;
      end
      S_SCAN_COLD: begin
        if (scan_q >= cold_fill_i) begin
          scan_q <= '0;
        end else if (match_w) begin
          hit_idx_q <= scan_q[LIST_AW-1:0];
        end else begin
          scan_q <= scan_q + CNT_W'(1);
        end
      end
      S_SCAN_HOT: begin
        if ((scan_q < hot_fill_i) && match_w) begin
          hit_idx_q <= scan_q[LIST_AW-1:0];
        end else begin
          scan_q <= scan_q + CNT_W'(1);
        end
      end
      S_COLD_HIT: begin
        hit_kind_q <= HIT_COLD;
        demote_q   <= hot_full_w;
        tail_q     <= hot_rd_i;
      end
      S_COLD_MOVE: begin
        if (demote_q && (cold_fill_i >= cold_cap_i)) begin
          drop_valid_q <= 1'b1;
          drop_page_q  <= tail_q;
        end
      end
      S_HOT_MOVE: begin
        hit_kind_q <= HIT_HOT;
      end
      S_MISS: begin
        if (cold_full_w) begin
          drop_valid_q <= 1'b1;
          drop_page_q  <= cold_rd_i;
        end
      end
      S_READ: begin
        if (op_q == OP_READ) begin
          read_valid_q <= rd_valid_w;
          if (rd_valid_w) read_page_q <= (sel_q == SEL_COLD) ? cold_rd_i : hot_rd_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (emit_w) begin
      out_hit_kind_o   <= hit_kind_q;
      out_read_valid_o <= read_valid_q;
      out_read_page_o  <= read_page_q;
      out_drop_valid_o <= drop_valid_q;
      out_drop_page_o  <= drop_page_q;
      out_hot_count_o  <= hot_fill_i;
      out_cold_count_o <= cold_fill_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== test/hcq_checker.sv =====
`timescale 1ns / 1ps

module hcq_checker import hcq_pkg::*; #(
  parameter int unsigned PAGE_BITS = DEF_PAGE_BITS,
  localparam int unsigned IN_W  = ((PAGE_BITS + POS_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * PAGE_BITS + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // page, position
  input  logic [1:0]       s_axis_tuser,   // op, list_select
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,   // read_page, dropped_page, hot_count, cold_count
  input  logic [3:0]       m_axis_tuser,   // hit_kind[1:0], read_valid, dropped_valid
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output int               errors_o,
  output int               pending_o
);

  localparam logic [2:0] HOT_CAP_ADDR  = {REG_HOT_CAP, 2'b00};
  localparam logic [2:0] COLD_CAP_ADDR = {REG_COLD_CAP, 2'b00};

  typedef struct packed {
    hit_kind_e              hit;
    logic                   rd_valid;
    logic [PAGE_BITS-1:0]   rd_page;
    logic                   drop_valid;
    logic [PAGE_BITS-1:0]   drop_page;
    logic [CNT_W-1:0]       hot_cnt;
    logic [CNT_W-1:0]       cold_cnt;
  } lookup_result_t;

  logic [PAGE_BITS-1:0] hot_list [HOT_DEPTH];
  logic [PAGE_BITS-1:0] cold_list [COLD_DEPTH];
  int                   hot_fill;
  int                   cold_fill;
  int                   hot_cap;
  int                   cold_cap;
  int                   fail_count;
  lookup_result_t       lookup_q [$];
  lookup_result_t       want;

  function automatic int clip_capacity(input logic [4:0] v, input int depth);
    int c;
    c = int'(v);
    if (c == 0) begin
      c = 1;
    end else if (c > depth) begin
      c = depth;
    end
    return c;
  endfunction

  function automatic void cold_push_head(input logic [PAGE_BITS-1:0] page);
    for (int i = cold_fill; i > 0; i--) begin
      cold_list[i] = cold_list[i-1];
    end
    cold_list[0] = page;
    cold_fill++;
  endfunction

  function automatic lookup_result_t apply_request(input logic op,
                                                   input logic [PAGE_BITS-1:0] page,
                                                   input logic sel,
                                                   input logic [POS_W-1:0] pos);
    lookup_result_t       r;
    int                   cold_at;
    int                   hot_at;
    logic [PAGE_BITS-1:0] tail;
    r = '0;
    r.hit = HIT_MISS;
    if (op == OP_READ) begin
      if (sel == SEL_HOT) begin
        if (int'(pos) < hot_fill) begin
          r.rd_valid = 1'b1;
          r.rd_page  = hot_list[pos];
        end
      end else begin
        if (int'(pos) < cold_fill) begin
          r.rd_valid = 1'b1;
          r.rd_page  = cold_list[pos];
        end
      end
    end else begin
      cold_at = -1;
      hot_at  = -1;
      for (int i = 0; i < cold_fill; i++) begin
        if (cold_at < 0 && cold_list[i] == page) cold_at = i;
      end
      for (int i = 0; i < hot_fill; i++) begin
        if (hot_at < 0 && hot_list[i] == page) hot_at = i;
      end
      if (cold_at >= 0) begin
        r.hit = HIT_COLD;
        for (int i = cold_at; i < cold_fill - 1; i++) begin
          cold_list[i] = cold_list[i+1];
        end
        cold_fill--;
        if (hot_fill >= hot_cap && hot_fill > 0) begin
          tail = hot_list[hot_fill-1];
          hot_fill--;
          if (cold_fill < cold_cap) begin
            cold_push_head(tail);
          end else begin
            r.drop_valid = 1'b1;
            r.drop_page  = tail;
          end
        end
        for (int i = hot_fill; i > 0; i--) begin
          hot_list[i] = hot_list[i-1];
        end
        hot_list[0] = page;
        hot_fill++;
      end else if (hot_at >= 0) begin
        r.hit = HIT_HOT;
        for (int i = hot_at; i > 0; i--) begin
          hot_list[i] = hot_list[i-1];
        end
        hot_list[0] = page;
      end else begin
        if (cold_fill >= cold_cap && cold_fill > 0) begin
          r.drop_valid = 1'b1;
          r.drop_page  = cold_list[cold_fill-1];
          cold_fill--;
        end
        cold_push_head(page);
      end
    end
    r.hot_cnt  = CNT_W'(hot_fill);
    r.cold_cnt = CNT_W'(cold_fill);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HOT_DEPTH; i++) hot_list[i] = '0;
      for (int i = 0; i < COLD_DEPTH; i++) cold_list[i] = '0;
      hot_fill   = 0;
      cold_fill  = 0;
      hot_cap    = clip_capacity(5'(CAP_RESET), HOT_DEPTH);
      cold_cap   = clip_capacity(5'(CAP_RESET), COLD_DEPTH);
      fail_count = 0;
      lookup_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lookup_q.size() == 0) begin
          fail_count++;
          $error("result with no request outstanding");
        end else begin
          want = lookup_q.pop_front();
          check_field("hit_kind", 32'(want.hit), 32'(m_axis_tuser[1:0]));
          check_field("read_valid", 32'(want.rd_valid), 32'(m_axis_tuser[2]));
          check_field("read_page", 32'(want.rd_page), 32'(m_axis_tdata[PAGE_BITS-1:0]));
          check_field("dropped_valid", 32'(want.drop_valid), 32'(m_axis_tuser[3]));
          check_field("dropped_page", 32'(want.drop_page),
                      32'(m_axis_tdata[2*PAGE_BITS-1:PAGE_BITS]));
          check_field("hot_count", 32'(want.hot_cnt),
                      32'(m_axis_tdata[2*PAGE_BITS+CNT_W-1:2*PAGE_BITS]));
          check_field("cold_count", 32'(want.cold_cnt),
                      32'(m_axis_tdata[2*PAGE_BITS+2*CNT_W-1:2*PAGE_BITS+CNT_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lookup_q.push_back(apply_request(s_axis_tuser[0], s_axis_tdata[PAGE_BITS-1:0],
                                         s_axis_tuser[1],
                                         s_axis_tdata[PAGE_BITS+POS_W-1:PAGE_BITS]));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == HOT_CAP_ADDR) begin
          hot_cap = clip_capacity(pwdata[4:0], HOT_DEPTH);
          if (hot_fill > hot_cap) hot_fill = hot_cap;
        end else if (paddr == COLD_CAP_ADDR) begin
          cold_cap = clip_capacity(pwdata[4:0], COLD_DEPTH);
          if (cold_fill > cold_cap) cold_fill = cold_cap;
        end
      end
      errors_o  <= fail_count;
      pending_o <= lookup_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hcq_pkg::*;

  localparam int unsigned PAGE_BITS  = DEF_PAGE_BITS;
  localparam int unsigned IN_W       = ((PAGE_BITS + POS_W + 7) / 8) * 8;
  localparam int unsigned OUT_W      = ((2 * PAGE_BITS + 2 * CNT_W + 7) / 8) * 8;
  localparam int          PAGE_MAX   = (1 << PAGE_BITS) - 1;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          HOLD_LEN   = 400;
  localparam int          NUM_PHASES = 8;
  localparam int          PHASE_LEN  = 150;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // page, position
  logic [1:0]       s_axis_tuser;   // op, list_select
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // read_page, dropped_page, hot_count, cold_count
  logic [3:0]       m_axis_tuser;   // hit_kind[1:0], read_valid, dropped_valid
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int               errors;
  int               pending;
  int               idle_cycles;
  bit               hold_req;
  bit               no_gaps;
  logic [PAGE_BITS-1:0] page_pool [$];

  hot_cold_two_queue_replacement #(.PAGE_BITS(PAGE_BITS)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hcq_checker #(.PAGE_BITS(PAGE_BITS)) checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    no_gaps       = 1'b0;
  end

  task automatic send_request(input logic op, input logic [PAGE_BITS-1:0] page,
                              input logic sel, input logic [POS_W-1:0] pos);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({pos, page});
    s_axis_tuser  <= {sel, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_access(input logic [PAGE_BITS-1:0] page);
    send_request(OP_ACCESS, page, 1'($urandom), POS_W'($urandom));
  endtask

  task automatic send_read(input logic sel, input logic [POS_W-1:0] pos);
    send_request(OP_READ, PAGE_BITS'($urandom), sel, pos);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_capacity(input logic reg_idx, input logic [4:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {27'($urandom), cap};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [4:0] pick_capacity();
    logic [4:0] c;
    case ($urandom_range(0, 5))
      0:       c = 5'd0;
      1:       c = 5'd1;
      2:       c = 5'd16;
      3:       c = 5'($urandom_range(17, 31));
      default: c = 5'($urandom_range(2, 15));
    endcase
    return c;
  endfunction

  // receiver: random stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[hot_cold_two_queue_replacement] ERROR");
      $finish;
    end
  end
  initial idle_cycles = 0;

  initial begin
    int burst_left;
    int gap;
    int pick;
    logic [4:0] hot_cap;
    logic [4:0] cold_cap;
    burst_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty lists, then misses, hits and moves at the page extremes
    send_read(SEL_HOT, 4'd0);
    send_read(SEL_COLD, 4'd15);
    send_access(PAGE_BITS'(0));
    send_access(PAGE_BITS'(PAGE_MAX));
    send_access(PAGE_BITS'(0));
    send_access(PAGE_BITS'(0));
    send_access(PAGE_BITS'(PAGE_MAX));
    send_read(SEL_HOT, 4'd0);
    send_read(SEL_HOT, 4'd1);
    send_read(SEL_COLD, 4'd0);
    drain_results();

    // zero capacities act as one and truncate the hot list silently
    write_capacity(REG_HOT_CAP, 5'd0);
    write_capacity(REG_COLD_CAP, 5'd0);
    send_access(PAGE_BITS'(5));
    send_access(PAGE_BITS'(7));
    send_access(PAGE_BITS'(7));
    send_access(PAGE_BITS'(9));
    send_access(PAGE_BITS'(9));
    send_read(SEL_HOT, 4'd0);
    send_read(SEL_COLD, 4'd0);
    send_read(SEL_COLD, 4'd15);
    drain_results();
    write_capacity(REG_HOT_CAP, 5'd31);
    write_capacity(REG_COLD_CAP, 5'd17);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin hot_cap = 5'd1;  cold_cap = 5'd16; end
        1:       begin hot_cap = 5'd16; cold_cap = 5'd1;  end
        2:       begin hot_cap = 5'd16; cold_cap = 5'd16; end
        default: begin hot_cap = pick_capacity(); cold_cap = pick_capacity(); end
      endcase
      if (phase > 0) begin
        write_capacity(REG_HOT_CAP, hot_cap);
        write_capacity(REG_COLD_CAP, cold_cap);
      end
      page_pool.delete();
      repeat ($urandom_range(2, 40)) page_pool.push_back(PAGE_BITS'($urandom));
      no_gaps = (phase == 5);
      if (phase == 4) hold_req = 1'b1;

      for (int n = 0; n < PHASE_LEN; n++) begin
        if (burst_left == 0) begin
          gap = no_gaps ? 0 : $urandom_range(0, 8);
          if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          send_access(page_pool[$urandom_range(0, page_pool.size() - 1)]);
        end else if (pick < 84) begin
          send_access(PAGE_BITS'($urandom));
        end else begin
          send_read(1'($urandom), POS_W'($urandom));
        end
      end
      drain_results();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[hot_cold_two_queue_replacement] OK");
    end else begin
      $display("[hot_cold_two_queue_replacement] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hcq_pkg.sv
rtl/hcq_list.sv
rtl/hcq_ctrl.sv
rtl/hot_cold_two_queue_replacement.sv
test/hcq_checker.sv
test/tb.sv
